[hw/rtl/mdv_pkg.sv]
package mdv_pkg;

    localparam int NUM_CH          = 5;
    localparam int SAMPLE_W        = 10;
    localparam int AVG_FRAC        = 8;
    localparam int AVG_W           = 18;
    localparam int DEV_FRAC        = 12;
    localparam int DEV_W           = 22;
    localparam int CFG_W           = 8;
    localparam int CH_W            = 3;
    localparam int ANGLE_W         = 8;
    localparam int HISTORY_DEPTH_D = 10;
    localparam int MAX_WINDOW_D    = 150;
    localparam logic [CFG_W-1:0] WINDOW_RESET = 8'd100;
    localparam int ANGLE_STEP      = 45;

    // dividend width for both division kinds (average and deviation)
    localparam int DIV_NUM_W = AVG_W + DEV_FRAC + 1;
    localparam int DIV_DEN_W = AVG_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    function automatic logic [ANGLE_W-1:0] angle_of(input logic [CH_W-1:0] ch);
        logic [ANGLE_W-1:0] a;
        case (ch)
            3'd0:    a = 8'd0;
            3'd1:    a = 8'd45;
            3'd2:    a = 8'd90;
            3'd3:    a = 8'd135;
            3'd4:    a = 8'd180;
            default: a = 8'd0;
        endcase
        return a;
    endfunction

endpackage

[hw/rtl/mdv_divider.sv]
module mdv_divider (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [mdv_pkg::DIV_NUM_W-1:0]      num,
    input  logic [mdv_pkg::DIV_DEN_W-1:0]      den,
    output logic                               done,
    output logic [mdv_pkg::DIV_NUM_W-1:0]      quo
);
    localparam int NW = mdv_pkg::DIV_NUM_W;
    localparam int DW = mdv_pkg::DIV_DEN_W;
    localparam int CW = mdv_pkg::DIV_CNT_W;

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next, done_reg, done_next;
    logic [DW+1:0] trial;
    logic [DW+1:0] sh;

    // restoring radix-2, one quotient bit per cycle
    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sh        = {r_reg, q_reg[NW-1]};
        trial     = sh - {2'b00, d_reg};
        if (start) begin
            q_next    = num;
            r_next    = '0;
            d_next    = den;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[DW+1]) begin
                r_next = trial[DW:0];
                q_next = {q_reg[NW-2:0], 1'b1};
            end else begin
                r_next = sh[DW:0];
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;
endmodule

[hw/rtl/mic_array_direction_vote_core.sv]
// Channel  | Dir | Handshake         | Payload
// s_axis   | in  | s_tvalid/s_tready | s_tdata: mic_one..mic_five, 10 bits each
// m_axis   | out | m_tvalid/m_tready | m_tdata: winning_channel[2:0], direction_angle[10:3]
// cfg      | in  | cfg_valid/ready   | cfg_data: window_samples
// A new sample set is taken only after the last is done; its pace is set by the shared
// bit-serial divider (one quotient bit per cycle, up to ten divisions per item); a zero
// average skips its deviation divide. A window's end adds a scan of the win counts.
// Reset (aresetn low, synchronous) clears history, averages, counts; window back to 100.
// The result sits in an output register; a new item is taken while it waits,
// but the next window result stalls the block until the previous one leaves.
module mic_array_direction_vote_core #(
    parameter int HISTORY_DEPTH = mdv_pkg::HISTORY_DEPTH_D,
    parameter int MAX_WINDOW    = mdv_pkg::MAX_WINDOW_D
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // mic_one, mic_two, mic_three, mic_four, mic_five
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // winning_channel, direction_angle
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    localparam int NC  = mdv_pkg::NUM_CH;
    localparam int SW  = mdv_pkg::SAMPLE_W;
    localparam int AW  = mdv_pkg::AVG_W;
    localparam int DW  = mdv_pkg::DEV_W;
    localparam int NW  = mdv_pkg::DIV_NUM_W;
    localparam int HW  = $clog2(HISTORY_DEPTH + 1);
    localparam int HIW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SUMW = SW + HW;

    typedef enum logic [3:0] {
        S_IDLE, S_DEV_START, S_DEV_WAIT, S_SHIFT, S_SUM, S_AVG_START,
        S_AVG_WAIT, S_NEXT, S_VOTE, S_EMIT
    } state_t;

    state_t state_reg;
    logic [SW-1:0]  x_reg [NC];
    logic [SW-1:0]  hist_reg [NC][HISTORY_DEPTH];
    logic [AW-1:0]  avg_reg [NC];
    logic [7:0]     wins_reg [NC];
    logic [7:0]     pos_reg;
    logic [7:0]     win_lim_reg;
    logic [2:0]     ch_reg;
    logic [HIW-1:0] hi_reg;
    logic [SUMW-1:0] sum_reg;
    logic [HW-1:0]  cnt_reg;
    logic [DW-1:0]  best_reg;
    logic [2:0]     winner_reg;
    logic           m_valid_reg;
    logic [2:0]     m_ch_reg;
    logic [7:0]     top_reg;
    logic [2:0]     best_ch_reg;

    logic           div_start;
    logic [NW-1:0]  div_num;
    logic [AW-1:0]  div_den;
    logic           div_done;
    logic [NW-1:0]  div_quo;

    mdv_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(div_num),
        .den(div_den), .done(div_done), .quo(div_quo)
    );

    logic [AW-1:0] xs;
    logic [AW-1:0] diff;
    logic [7:0]    lim;
    logic [DW-1:0] dev;
    logic          emit_fire;

    always_comb begin
        xs   = {x_reg[ch_reg], 8'd0};
        diff = (xs >= avg_reg[ch_reg]) ? xs - avg_reg[ch_reg] : avg_reg[ch_reg] - xs;
        lim  = (win_lim_reg == 8'd0) ? 8'd1 :
               (win_lim_reg > 8'(MAX_WINDOW)) ? 8'(MAX_WINDOW) : win_lim_reg;
        dev  = (div_quo > NW'({DW{1'b1}})) ? {DW{1'b1}} : div_quo[DW-1:0];
        div_start = (state_reg == S_DEV_START) || (state_reg == S_AVG_START);
        if (state_reg == S_DEV_START) begin
            div_num = NW'({diff, 12'd0});
            div_den = avg_reg[ch_reg];
        end else begin
            div_num = NW'({sum_reg, 8'd0});
            div_den = AW'(cnt_reg);
        end
    end

    assign emit_fire = (state_reg == S_EMIT) && (ch_reg == 3'(NC)) &&
                       (!m_valid_reg || m_tready);

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {5'd0, mdv_pkg::angle_of(m_ch_reg), m_ch_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            pos_reg     <= '0;
            win_lim_reg <= mdv_pkg::WINDOW_RESET;
            for (int c = 0; c < NC; c++) begin
                avg_reg[c]  <= '0;
                wins_reg[c] <= '0;
                for (int i = 0; i < HISTORY_DEPTH; i++) hist_reg[c][i] <= '0;
            end
        end else begin
            if (emit_fire) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready) win_lim_reg <= cfg_data;
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        for (int c = 0; c < NC; c++) x_reg[c] <= s_tdata[c*SW +: SW];
                        if (avg_reg[0] == '0 && avg_reg[1] == '0 && avg_reg[2] == '0 &&
                            avg_reg[3] == '0 && avg_reg[4] == '0) begin
                            for (int c = 0; c < NC; c++)
                                avg_reg[c] <= {s_tdata[c*SW +: SW], 8'd0};
                        end
                        ch_reg     <= '0;
                        best_reg   <= '0;
                        winner_reg <= '0;
                        state_reg  <= S_DEV_START;
                    end
                end
                S_DEV_START: begin
                    state_reg <= (avg_reg[ch_reg] == '0) ? S_NEXT : S_DEV_WAIT;
                end
                S_DEV_WAIT: begin
                    if (div_done) begin
                        if (dev > best_reg) begin
                            best_reg   <= dev;
                            winner_reg <= ch_reg;
                        end
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (ch_reg == 3'(NC - 1)) begin
                        ch_reg    <= '0;
                        state_reg <= S_SHIFT;
                    end else begin
                        ch_reg    <= ch_reg + 1'b1;
                        state_reg <= S_DEV_START;
                    end
                end
                S_SHIFT: begin
                    for (int i = HISTORY_DEPTH - 1; i > 0; i--)
                        hist_reg[ch_reg][i] <= hist_reg[ch_reg][i-1];
                    hist_reg[ch_reg][0] <= x_reg[ch_reg];
                    sum_reg   <= '0;
                    cnt_reg   <= '0;
                    hi_reg    <= '0;
                    state_reg <= S_SUM;
                end
                S_SUM: begin
                    if (hist_reg[ch_reg][hi_reg] != '0) begin
                        sum_reg <= sum_reg + SUMW'(hist_reg[ch_reg][hi_reg]);
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (hi_reg == HIW'(HISTORY_DEPTH - 1)) state_reg <= S_AVG_START;
                    else hi_reg <= hi_reg + 1'b1;
                end
                S_AVG_START: begin
                    if (cnt_reg == '0) begin
                        avg_reg[ch_reg] <= '0;
                        state_reg <= S_VOTE;
                    end else begin
                        state_reg <= S_AVG_WAIT;
                    end
                end
                S_AVG_WAIT: begin
                    if (div_done) begin
                        avg_reg[ch_reg] <= div_quo[AW-1:0];
                        state_reg <= S_VOTE;
                    end
                end
                S_VOTE: begin
                    if (ch_reg == 3'(NC - 1)) begin
                        wins_reg[winner_reg] <= wins_reg[winner_reg] + 1'b1;
                        pos_reg   <= pos_reg + 1'b1;
                        ch_reg    <= '0;
                        top_reg   <= '0;
                        best_ch_reg <= '0;
                        state_reg <= (pos_reg + 1'b1 >= lim) ? S_EMIT : S_IDLE;
                    end else begin
                        ch_reg    <= ch_reg + 1'b1;
                        state_reg <= S_SHIFT;
                    end
                end
                S_EMIT: begin
                    if (ch_reg < 3'(NC)) begin
                        if (wins_reg[ch_reg] > top_reg) begin
                            top_reg     <= wins_reg[ch_reg];
                            best_ch_reg <= ch_reg;
                        end
                        ch_reg <= ch_reg + 1'b1;
                    end else if (emit_fire) begin
                        m_ch_reg    <= best_ch_reg;
                        pos_reg     <= '0;
                        for (int c = 0; c < NC; c++) wins_reg[c] <= '0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_ch_reg < 3'(NC)) else $error("channel out of range");
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> pos_reg < 8'(MAX_WINDOW)) else $error("window overrun");
endmodule
